[rtl/ipsp_pkg.sv]
// ----------------------------------------------------------------------------
// ipsp_pkg
// Shared types and constants of the IPS / IPS32 patch stream parser.
// ----------------------------------------------------------------------------
package ipsp_pkg;

    localparam int unsigned HEADER_BYTES_DEFAULT = 256;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_OFFSETS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SIZE   = 2'd1;

    // parser phases
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_OFFSET  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RLE_LEN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RLE_VAL = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TAIL    = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_TAIL  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // tail markers, "EOF" and "EEOF"
    localparam logic [31:0] TAIL_NARROW = 32'h0045_4F46;
    localparam logic [31:0] TAIL_WIDE   = 32'h4545_4F46;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [7:0] patch_byte;
        logic       final_byte;
    } patch_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [15:0] run_length;
        logic [7:0]  value;
        logic        whole_records;
        logic        last_of_run;
    } result_t;

    // results of one patch byte, first entry goes out first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[rtl/ips_patch_stream_parser.sv]
// ----------------------------------------------------------------------------
// ips_patch_stream_parser
// Parses IPS / IPS32 patch records byte by byte into image writes and fills.
// ----------------------------------------------------------------------------
// one patch byte is taken per cycle and decoded in the same cycle; its results
// (at most two: a write, fill or tail transaction, then a stream-end
// transaction on the final byte) enter a four-entry result queue and are
// offered from the next cycle on; patch_ready is high while the queue has two
// free slots, so the sustained rate is one byte per cycle as long as the
// result side takes one transaction per cycle; configuration writes are always
// taken and must only be done while the parser is idle
module ips_patch_stream_parser #(
    parameter int unsigned HEADER_BYTES = ipsp_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               patch_valid,
    output logic                               patch_ready,
    input  ipsp_pkg::patch_t                   patch,
    output logic                               result_valid,
    input  logic                               result_ready,
    output ipsp_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ipsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);

    logic            wide_offsets_reg;
    logic [31:0]     image_size_reg;
    logic            accept;
    ipsp_pkg::push_t push;

    assign cfg_ready = 1'b1;
    assign accept    = patch_valid && patch_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_offsets_reg <= 1'b0;
            image_size_reg   <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipsp_pkg::CFG_WIDE_OFFSETS:
                begin
                    wide_offsets_reg <= cfg_data[0];
                end
                ipsp_pkg::CFG_IMAGE_SIZE:
                begin
                    image_size_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    ipsp_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (patch),
        .wide_offsets (wide_offsets_reg),
        .image_size   (image_size_reg),
        .push         (push)
    );

    ipsp_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_en      (accept),
        .push         (push),
        .room         (patch_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[rtl/ipsp_core.sv]
// ----------------------------------------------------------------------------
// ipsp_core
// Record parser state and per-byte decode: offset, size, RLE and payload
// fields, header shift and image clipping, up to two results per byte.
// ----------------------------------------------------------------------------
module ipsp_core #(
    parameter int unsigned HEADER_BYTES = ipsp_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  ipsp_pkg::patch_t item,
    input  logic            wide_offsets,
    input  logic [31:0]     image_size,
    output ipsp_pkg::push_t push
);

    logic [ipsp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [15:0] byte_counter_reg, byte_counter_next;
    logic [31:0] record_offset_reg, record_offset_next;
    logic [15:0] record_size_reg, record_size_next;
    logic [15:0] fill_length_reg, fill_length_next;
    logic        tail_seen_reg, tail_seen_next;

    logic [16:0] cnt_inc;
    logic [16:0] off_width;
    logic [31:0] off_acc;
    logic [31:0] off_tail;
    logic [15:0] size_acc;
    logic [15:0] fill_acc;

    logic [32:0] hdr33;
    logic [32:0] fill_end;
    logic        fill_skip;
    logic        fill_in_hdr;
    logic [31:0] fill_addr;
    logic [15:0] fill_len1;
    logic        fill_over;
    logic [15:0] fill_len;
    logic        fill_emit;

    logic [32:0] pay_addr;
    logic [32:0] pay_rel;
    logic        pay_emit;

    logic                  data_valid;
    ipsp_pkg::result_t     data_res;
    ipsp_pkg::result_t     end_res;
    logic                  whole;

    // fill and payload clipping
    always_comb
    begin
        hdr33       = 33'(HEADER_BYTES);
        fill_end    = 33'(record_offset_reg) + 33'(fill_length_reg);
        fill_skip   = fill_end <= hdr33;
        fill_in_hdr = 33'(record_offset_reg) < hdr33;
        fill_addr   = fill_in_hdr ? 32'd0 : record_offset_reg - 32'(HEADER_BYTES);
        fill_len1   = fill_in_hdr ? 16'(fill_end - hdr33) : fill_length_reg;
        fill_over   = (33'(fill_addr) + 33'(fill_len1)) > 33'(image_size);
        if (fill_addr >= image_size)
        begin
            fill_len = 16'd0;
        end
        else if (fill_over)
        begin
            fill_len = 16'(image_size - fill_addr);
        end
        else
        begin
            fill_len = fill_len1;
        end
        fill_emit = !fill_skip && (fill_len != 16'd0);

        pay_addr = 33'(record_offset_reg) + 33'(byte_counter_reg);
        pay_rel  = pay_addr - hdr33;
        pay_emit = (pay_addr >= hdr33) && (pay_rel < 33'(image_size));
    end

    always_comb
    begin
        phase_next         = phase_reg;
        byte_counter_next  = byte_counter_reg;
        record_offset_next = record_offset_reg;
        record_size_next   = record_size_reg;
        fill_length_next   = fill_length_reg;
        tail_seen_next     = tail_seen_reg;
        data_valid         = 1'b0;
        data_res           = '0;
        end_res            = '0;
        whole              = 1'b0;

        cnt_inc   = 17'(byte_counter_reg) + 17'd1;
        off_width = wide_offsets ? 17'd4 : 17'd3;
        off_tail  = wide_offsets ? ipsp_pkg::TAIL_WIDE : ipsp_pkg::TAIL_NARROW;
        off_acc   = {((byte_counter_reg == 16'd0) ? 24'd0 : record_offset_reg[23:0]),
                     item.patch_byte};
        size_acc  = {record_size_reg[7:0], item.patch_byte};
        fill_acc  = {fill_length_reg[7:0], item.patch_byte};

        case (phase_reg)
            ipsp_pkg::PH_OFFSET:
            begin
                record_offset_next = off_acc;
                byte_counter_next  = cnt_inc[15:0];
                if (cnt_inc >= off_width)
                begin
                    byte_counter_next = 16'd0;
                    if (off_acc == off_tail)
                    begin
                        tail_seen_next = 1'b1;
                        phase_next     = ipsp_pkg::PH_TAIL;
                        data_valid     = 1'b1;
                        data_res.kind  = ipsp_pkg::KIND_TAIL;
                    end
                    else
                    begin
                        record_size_next = 16'd0;
                        phase_next       = ipsp_pkg::PH_SIZE;
                    end
                end
            end
            ipsp_pkg::PH_SIZE:
            begin
                record_size_next  = size_acc;
                byte_counter_next = cnt_inc[15:0];
                if (cnt_inc >= 17'd2)
                begin
                    byte_counter_next = 16'd0;
                    if (size_acc == 16'd0)
                    begin
                        fill_length_next = 16'd0;
                        phase_next       = ipsp_pkg::PH_RLE_LEN;
                    end
                    else
                    begin
                        phase_next = ipsp_pkg::PH_PAYLOAD;
                    end
                end
            end
            ipsp_pkg::PH_RLE_LEN:
            begin
                fill_length_next  = fill_acc;
                byte_counter_next = cnt_inc[15:0];
                if (cnt_inc >= 17'd2)
                begin
                    byte_counter_next = 16'd0;
                    phase_next        = ipsp_pkg::PH_RLE_VAL;
                end
            end
            ipsp_pkg::PH_RLE_VAL:
            begin
                data_valid          = fill_emit;
                data_res.kind       = ipsp_pkg::KIND_FILL;
                data_res.address    = fill_addr;
                data_res.run_length = fill_len;
                data_res.value      = item.patch_byte;
                byte_counter_next   = 16'd0;
                phase_next          = ipsp_pkg::PH_OFFSET;
            end
            ipsp_pkg::PH_PAYLOAD:
            begin
                data_valid        = pay_emit;
                data_res.kind     = ipsp_pkg::KIND_WRITE;
                data_res.address  = pay_rel[31:0];
                data_res.value    = item.patch_byte;
                byte_counter_next = cnt_inc[15:0];
                if (cnt_inc >= 17'(record_size_reg))
                begin
                    byte_counter_next = 16'd0;
                    phase_next        = ipsp_pkg::PH_OFFSET;
                end
            end
            default:
            begin
                phase_next = ipsp_pkg::PH_TAIL;
            end
        endcase

        // stream end closes the patch and returns to the start
        if (item.final_byte)
        begin
            whole = tail_seen_next ||
                    ((phase_next == ipsp_pkg::PH_OFFSET) && (byte_counter_next == 16'd0));
            end_res.kind          = ipsp_pkg::KIND_END;
            end_res.whole_records = whole;
            end_res.last_of_run   = 1'b1;
            phase_next            = ipsp_pkg::PH_OFFSET;
            byte_counter_next     = 16'd0;
            record_offset_next    = 32'd0;
            record_size_next      = 16'd0;
            fill_length_next      = 16'd0;
            tail_seen_next        = 1'b0;
        end
        data_res.last_of_run = !item.final_byte;

        push.count  = 2'(data_valid) + 2'(item.final_byte);
        push.first  = data_valid ? data_res : end_res;
        push.second = end_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ipsp_pkg::PH_OFFSET;
            byte_counter_reg  <= 16'd0;
            record_offset_reg <= 32'd0;
            record_size_reg   <= 16'd0;
            fill_length_reg   <= 16'd0;
            tail_seen_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            byte_counter_reg  <= byte_counter_next;
            record_offset_reg <= record_offset_next;
            record_size_reg   <= record_size_next;
            fill_length_reg   <= fill_length_next;
            tail_seen_reg     <= tail_seen_next;
        end
    end

endmodule

[rtl/ipsp_result_queue.sv]
// ----------------------------------------------------------------------------
// ipsp_result_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ipsp_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_en,
    input  ipsp_pkg::push_t    push,
    output logic               room,
    output logic               result_valid,
    input  logic               result_ready,
    output ipsp_pkg::result_t  result
);

    ipsp_pkg::result_t entry_reg [ipsp_pkg::QUEUE_DEPTH];

    logic [ipsp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ipsp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ipsp_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [ipsp_pkg::QUEUE_PTR_W-1:0] wr_ptr_1;
    logic [1:0] push_n;
    logic       pop;

    always_comb
    begin
        push_n      = push_en ? push.count : 2'd0;
        pop         = result_valid && result_ready;
        wr_ptr_1    = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + ipsp_pkg::QUEUE_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + ipsp_pkg::QUEUE_PTR_W'(pop);
        count_next  = count_reg + ipsp_pkg::QUEUE_CNT_W'(push_n)
                      - ipsp_pkg::QUEUE_CNT_W'(pop);
    end

    assign room         = count_reg <= ipsp_pkg::QUEUE_CNT_W'(ipsp_pkg::QUEUE_DEPTH - 2);
    assign result_valid = count_reg != '0;
    assign result       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
